// File: design/rc_pulse_capture_normalizer_assert.svh
// Assertion macros used by the checker of the pulse capture block.
`ifndef RC_PULSE_CAPTURE_NORMALIZER_ASSERT_SVH
`define RC_PULSE_CAPTURE_NORMALIZER_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define RCPN_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define RCPN_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define RCPN_ASSERT_ALW(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/rcpn_pkg.sv
`default_nettype none

package rcpn_pkg;

   localparam logic CMD_EDGE  = 1'b0;
   localparam logic CMD_FRAME = 1'b1;

   localparam logic [2:0] CSR_PULSE_MIN = 3'd0;
   localparam logic [2:0] CSR_PULSE_MID = 3'd1;
   localparam logic [2:0] CSR_PULSE_MAX = 3'd2;
   localparam logic [2:0] CSR_DEADBAND  = 3'd3;
   localparam logic [2:0] CSR_ROLL_CH   = 3'd4;
   localparam logic [2:0] CSR_PITCH_CH  = 3'd5;
   localparam logic [2:0] CSR_YAW_CH    = 3'd6;
   localparam logic [2:0] CSR_THR_CH    = 3'd7;

   // Width of a channel select; covers every channel count up to thirty-one.
   localparam int SEL_W = 5;

   localparam logic [15:0] RESET_MIN      = 16'd1000;
   localparam logic [15:0] RESET_MID      = 16'd1500;
   localparam logic [15:0] RESET_MAX      = 16'd2000;
   localparam logic [13:0] RESET_DEADBAND = 14'd819;
   localparam logic [2:0]  RESET_ROLL_CH  = 3'd0;
   localparam logic [2:0]  RESET_PITCH_CH = 3'd1;
   localparam logic [2:0]  RESET_YAW_CH   = 3'd3;
   localparam logic [2:0]  RESET_THR_CH   = 3'd2;

   typedef struct packed {
      logic [15:0] pulse_min;
      logic [15:0] pulse_mid;
      logic [15:0] pulse_max;
      logic [13:0] deadband;
      logic [2:0]  roll_ch;
      logic [2:0]  pitch_ch;
      logic [2:0]  yaw_ch;
      logic [2:0]  thr_ch;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      pulse_min: RESET_MIN,
      pulse_mid: RESET_MID,
      pulse_max: RESET_MAX,
      deadband:  RESET_DEADBAND,
      roll_ch:   RESET_ROLL_CH,
      pitch_ch:  RESET_PITCH_CH,
      yaw_ch:    RESET_YAW_CH,
      thr_ch:    RESET_THR_CH
   };

   typedef struct packed {
      logic        valid;
      logic [2:0]  channel;
      logic        level;
      logic [31:0] stamp;
   } edge_type;

   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
      logic signed [15:0] yaw;
      logic [14:0]        throttle;
      logic               armed;
   } result_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_CHECK,
      DIV_RUN
   } div_state_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_FETCH,
      SEQ_SPAN,
      SEQ_WAIT_SPAN,
      SEQ_DBAND,
      SEQ_WAIT_DBAND,
      SEQ_ARM,
      SEQ_HOLD
   } seq_state_type;

   typedef enum logic [2:0] {
      AXIS_ROLL,
      AXIS_PITCH,
      AXIS_YAW,
      AXIS_THR,
      AXIS_ARM
   } axis_type;

   // Signed operand width of the divider: holds a 16-bit width difference
   // and a fraction of one in either sign.
   function automatic int span_width(input int frac_bits);
      return (frac_bits + 2 > 17) ? frac_bits + 2 : 17;
   endfunction

endpackage

`default_nettype wire

// File: design/rcpn_serial_div.sv
`default_nettype none

// Bit-serial signed divider for ratios whose magnitude is at most one:
// q = trunc(num * 2^FRAC_BITS / den), saturated to +-2^FRAC_BITS, zero
// when den is zero. One quotient bit is shifted in per cycle.
module rcpn_serial_div #(
   parameter int FRAC_BITS = 14,
   localparam int W = rcpn_pkg::span_width(FRAC_BITS),
   localparam int QW = FRAC_BITS + 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [W-1:0]  num,
   input  logic signed [W-1:0]  den,
   output logic                 done,
   output logic signed [QW-1:0] q
);

   localparam int MW = W - 1;
   localparam int CW = $clog2(FRAC_BITS + 1);
   localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [CW-1:0] LAST = CW'(FRAC_BITS);

   rcpn_pkg::div_state_type state_ff, state_in;
   logic                    done_ff, done_in;
   logic [MW-1:0]           num_mag_ff, num_mag_in;
   logic [MW-1:0]           den_ff, den_in;
   logic                    neg_ff, neg_in;
   logic [W-1:0]            rem_ff, rem_in;
   logic [FRAC_BITS:0]      quo_ff, quo_in;
   logic [CW-1:0]           cnt_ff, cnt_in;

   logic signed [W-1:0] num_abs;
   logic signed [W-1:0] den_abs;
   logic                ge;
   logic [W-1:0]        rem_sub;
   logic [W-1:0]        rem_sel;

   assign num_abs = num[W-1] ? -num : num;
   assign den_abs = den[W-1] ? -den : den;
   assign ge      = rem_ff >= {1'b0, den_ff};
   assign rem_sub = rem_ff - {1'b0, den_ff};
   assign rem_sel = ge ? rem_sub : rem_ff;

   always_comb begin
      state_in   = state_ff;
      done_in    = 1'b0;
      num_mag_in = num_mag_ff;
      den_in     = den_ff;
      neg_in     = neg_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      case (state_ff)
         rcpn_pkg::DIV_IDLE: begin
            if (start) begin
               num_mag_in = num_abs[MW-1:0];
               den_in     = den_abs[MW-1:0];
               neg_in     = num[W-1] ^ den[W-1];
               state_in   = rcpn_pkg::DIV_CHECK;
            end
         end
         rcpn_pkg::DIV_CHECK: begin
            if (den_ff == '0) begin
               quo_in   = '0;
               done_in  = 1'b1;
               state_in = rcpn_pkg::DIV_IDLE;
            end else if (num_mag_ff > den_ff) begin
               // The ratio is above one, so it saturates.
               quo_in   = ONE_Q;
               done_in  = 1'b1;
               state_in = rcpn_pkg::DIV_IDLE;
            end else begin
               rem_in   = {1'b0, num_mag_ff};
               quo_in   = '0;
               cnt_in   = '0;
               state_in = rcpn_pkg::DIV_RUN;
            end
         end
         rcpn_pkg::DIV_RUN: begin
            rem_in = {rem_sel[W-2:0], 1'b0};
            quo_in = {quo_ff[FRAC_BITS-1:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               done_in  = 1'b1;
               state_in = rcpn_pkg::DIV_IDLE;
            end
         end
         default: begin
            state_in = rcpn_pkg::DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rcpn_pkg::DIV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      num_mag_ff <= num_mag_in;
      den_ff     <= den_in;
      neg_ff     <= neg_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
   end

   assign done = done_ff;
   assign q    = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

endmodule

`default_nettype wire

// File: design/rcpn_pulse_store.sv
`default_nettype none

// Per-channel edge times and measured pulse widths.
module rcpn_pulse_store #(
   parameter int CHANNELS = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  rcpn_pkg::edge_type           edge_ev,
   input  logic [rcpn_pkg::SEL_W-1:0]   rd_sel,
   output logic [15:0]                  rd_width
);

   localparam int SW = rcpn_pkg::SEL_W;
   localparam int IDX_W = $clog2(CHANNELS);
   localparam logic [SW-1:0] CHAN_LIMIT = SW'(CHANNELS);

   logic [31:0] start_times_ff [CHANNELS];
   logic [15:0] pulse_widths_ff [CHANNELS];

   logic [SW-1:0]    chan_wide;
   logic             chan_ok;
   logic [IDX_W-1:0] chan_idx;
   logic [31:0]      delta;
   logic [15:0]      width_sat;

   assign chan_wide = SW'(edge_ev.channel);
   assign chan_ok   = chan_wide < CHAN_LIMIT;
   assign chan_idx  = chan_wide[IDX_W-1:0];
   assign delta     = edge_ev.stamp - start_times_ff[chan_idx];
   assign width_sat = (delta[31:16] != '0) ? 16'hFFFF : delta[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            start_times_ff[i]  <= '0;
            pulse_widths_ff[i] <= (i == int'(rcpn_pkg::RESET_THR_CH)) ?
                                  rcpn_pkg::RESET_MIN : rcpn_pkg::RESET_MID;
         end
      end else if (edge_ev.valid && chan_ok) begin
         if (edge_ev.level) begin
            start_times_ff[chan_idx] <= edge_ev.stamp;
         end else begin
            pulse_widths_ff[chan_idx] <= width_sat;
         end
      end
   end

   // A select beyond the last channel reads as a zero width.
   assign rd_width = (rd_sel < CHAN_LIMIT) ? pulse_widths_ff[rd_sel[IDX_W-1:0]] : '0;

endmodule

`default_nettype wire

// File: design/rcpn_frame_seq.sv
`default_nettype none

// Frame sequencer: walks roll, pitch, yaw, throttle and the arm switch,
// clamping each width and running the normalizing divisions on one
// shared bit-serial divider.
module rcpn_frame_seq #(
   parameter int ARM_CHANNEL = 4,
   parameter int FRAC_BITS = 14
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  rcpn_pkg::cfg_type          cfg,
   output logic [rcpn_pkg::SEL_W-1:0] rd_sel,
   input  logic [15:0]                rd_width,
   output logic                       idle,
   output logic                       res_valid,
   input  logic                       res_take,
   output rcpn_pkg::result_type       res
);

   localparam int SW = rcpn_pkg::SEL_W;
   localparam int W  = rcpn_pkg::span_width(FRAC_BITS);
   localparam int QW = FRAC_BITS + 2;
   localparam int TW = FRAC_BITS + 6;
   localparam int DB_UP = (FRAC_BITS >= 14) ? FRAC_BITS - 14 : 0;
   localparam int DB_DN = (FRAC_BITS < 14) ? 14 - FRAC_BITS : 0;
   localparam logic signed [W-1:0] ONE_W = W'(1) << FRAC_BITS;
   localparam logic [TW-1:0] ONE_T = TW'(1) << FRAC_BITS;

   rcpn_pkg::seq_state_type state_ff, state_in;
   rcpn_pkg::axis_type      axis_ff, axis_in, axis_next;
   logic [15:0]             p_ff, p_in;
   logic signed [QW-1:0]    x_ff, x_in;
   logic signed [QW-1:0]    roll_ff, roll_in;
   logic signed [QW-1:0]    pitch_ff, pitch_in;
   logic signed [QW-1:0]    yaw_ff, yaw_in;
   logic [FRAC_BITS:0]      thr_ff, thr_in;
   logic                    armed_ff, armed_in;

   logic                 div_start;
   logic signed [W-1:0]  div_num;
   logic signed [W-1:0]  div_den;
   logic                 div_done;
   logic signed [QW-1:0] div_q;

   logic [15:0]          p_clamp;
   logic signed [W-1:0]  p_ext, min_ext, mid_ext, max_ext;
   logic signed [W-1:0]  span_num, span_den;
   logic signed [W-1:0]  db_ext, x_ext, x_mag;
   logic signed [W-1:0]  band_num, band_den;
   logic                 in_band;
   logic [TW-1:0]        thr20;
   logic                 stick_we;
   logic signed [QW-1:0] stick_val;

   rcpn_serial_div #(
      .FRAC_BITS(FRAC_BITS)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num(div_num),
      .den(div_den),
      .done(div_done),
      .q(div_q)
   );

   always_comb begin
      case (axis_ff)
         rcpn_pkg::AXIS_ROLL:  rd_sel = SW'(cfg.roll_ch);
         rcpn_pkg::AXIS_PITCH: rd_sel = SW'(cfg.pitch_ch);
         rcpn_pkg::AXIS_YAW:   rd_sel = SW'(cfg.yaw_ch);
         rcpn_pkg::AXIS_THR:   rd_sel = SW'(cfg.thr_ch);
         default:              rd_sel = SW'(ARM_CHANNEL);
      endcase
   end

   always_comb begin
      case (axis_ff)
         rcpn_pkg::AXIS_ROLL:  axis_next = rcpn_pkg::AXIS_PITCH;
         rcpn_pkg::AXIS_PITCH: axis_next = rcpn_pkg::AXIS_YAW;
         default:              axis_next = rcpn_pkg::AXIS_THR;
      endcase
   end

   // Inverted limits: widths below the low one get it, others the high.
   assign p_clamp = (rd_width < cfg.pulse_min) ? cfg.pulse_min :
                    (rd_width > cfg.pulse_max) ? cfg.pulse_max : rd_width;

   assign p_ext   = $signed(W'(p_ff));
   assign min_ext = $signed(W'(cfg.pulse_min));
   assign mid_ext = $signed(W'(cfg.pulse_mid));
   assign max_ext = $signed(W'(cfg.pulse_max));

   assign span_num = (axis_ff == rcpn_pkg::AXIS_THR) ? p_ext - min_ext : p_ext - mid_ext;
   assign span_den = (axis_ff == rcpn_pkg::AXIS_THR) ? max_ext - min_ext : max_ext - mid_ext;

   assign db_ext   = $signed((W'(cfg.deadband) << DB_UP) >> DB_DN);
   assign x_ext    = W'(x_ff);
   assign x_mag    = x_ext[W-1] ? -x_ext : x_ext;
   assign in_band  = x_mag <= db_ext;
   assign band_num = x_ext[W-1] ? x_ext + db_ext : x_ext - db_ext;
   assign band_den = ONE_W - db_ext;

   assign thr20 = (TW'(thr_ff) << 4) + (TW'(thr_ff) << 2);

   always_comb begin
      state_in  = state_ff;
      axis_in   = axis_ff;
      p_in      = p_ff;
      x_in      = x_ff;
      roll_in   = roll_ff;
      pitch_in  = pitch_ff;
      yaw_in    = yaw_ff;
      thr_in    = thr_ff;
      armed_in  = armed_ff;
      div_start = 1'b0;
      div_num   = span_num;
      div_den   = span_den;
      stick_we  = 1'b0;
      stick_val = div_q;
      case (state_ff)
         rcpn_pkg::SEQ_IDLE: begin
            if (start) begin
               axis_in  = rcpn_pkg::AXIS_ROLL;
               state_in = rcpn_pkg::SEQ_FETCH;
            end
         end
         rcpn_pkg::SEQ_FETCH: begin
            p_in     = p_clamp;
            state_in = (axis_ff == rcpn_pkg::AXIS_ARM) ? rcpn_pkg::SEQ_ARM : rcpn_pkg::SEQ_SPAN;
         end
         rcpn_pkg::SEQ_SPAN: begin
            div_start = 1'b1;
            state_in  = rcpn_pkg::SEQ_WAIT_SPAN;
         end
         rcpn_pkg::SEQ_WAIT_SPAN: begin
            if (div_done) begin
               if (axis_ff == rcpn_pkg::AXIS_THR) begin
                  thr_in   = div_q[QW-1] ? '0 : div_q[FRAC_BITS:0];
                  axis_in  = rcpn_pkg::AXIS_ARM;
                  state_in = rcpn_pkg::SEQ_FETCH;
               end else begin
                  x_in     = div_q;
                  state_in = rcpn_pkg::SEQ_DBAND;
               end
            end
         end
         rcpn_pkg::SEQ_DBAND: begin
            if (in_band) begin
               stick_we  = 1'b1;
               stick_val = '0;
               axis_in   = axis_next;
               state_in  = rcpn_pkg::SEQ_FETCH;
            end else begin
               div_start = 1'b1;
               div_num   = band_num;
               div_den   = band_den;
               state_in  = rcpn_pkg::SEQ_WAIT_DBAND;
            end
         end
         rcpn_pkg::SEQ_WAIT_DBAND: begin
            if (div_done) begin
               stick_we = 1'b1;
               axis_in  = axis_next;
               state_in = rcpn_pkg::SEQ_FETCH;
            end
         end
         rcpn_pkg::SEQ_ARM: begin
            armed_in = (thr20 < ONE_T) && (p_ff > cfg.pulse_mid);
            state_in = rcpn_pkg::SEQ_HOLD;
         end
         rcpn_pkg::SEQ_HOLD: begin
            if (res_take) begin
               state_in = rcpn_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = rcpn_pkg::SEQ_IDLE;
         end
      endcase
      if (stick_we) begin
         case (axis_ff)
            rcpn_pkg::AXIS_ROLL:  roll_in  = stick_val;
            rcpn_pkg::AXIS_PITCH: pitch_in = stick_val;
            rcpn_pkg::AXIS_YAW:   yaw_in   = stick_val;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rcpn_pkg::SEQ_IDLE;
         axis_ff  <= rcpn_pkg::AXIS_ROLL;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
      p_ff     <= p_in;
      x_ff     <= x_in;
      roll_ff  <= roll_in;
      pitch_ff <= pitch_in;
      yaw_ff   <= yaw_in;
      thr_ff   <= thr_in;
      armed_ff <= armed_in;
   end

   assign idle      = state_ff == rcpn_pkg::SEQ_IDLE;
   assign res_valid = state_ff == rcpn_pkg::SEQ_HOLD;
   assign res = '{
      roll:     16'(roll_ff),
      pitch:    16'(pitch_ff),
      yaw:      16'(yaw_ff),
      throttle: 15'(thr_ff),
      armed:    armed_ff
   };

endmodule

`default_nettype wire

// File: design/rc_pulse_capture_normalizer.sv
// RC receiver pulse capture with stick normalization.
// req_* carries one item per beat. A pin-edge beat (req_command 0) updates
// the start time or the pulse width of req_channel as it is taken and gives
// no result; edges can be taken on consecutive cycles. A frame-read beat
// (req_command 1) yields one rsp_* beat with roll, pitch and yaw in signed
// fixed point, throttle in 0..one and the armed flag.
// A frame runs its divisions one after another on the shared bit-serial
// divider, one quotient bit per cycle: up to seven divisions, two per stick
// and one for throttle, with fetch and control steps per axis around them.
// Sticks inside the deadband skip their second division. req_ready is low
// while a frame runs and until its result enters the rsp_* output register,
// so no new beat is taken before then.
// The finished frame moves into the rsp_* output register, so a new beat is
// taken while an earlier result waits on rsp_ready; a second frame finishes
// and waits inside the block until that register frees up.
// csr_* writes a configuration register per beat and is always ready; write
// only while the block is idle. Reset restores the register defaults, zero
// start times, centered widths and a low throttle width.
`default_nettype none

module rc_pulse_capture_normalizer #(
   parameter int CHANNELS = 6,
   parameter int ARM_CHANNEL = 4,
   parameter int FRAC_BITS = 14
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_command,
   input  logic [2:0]         req_channel,
   input  logic               req_level,
   input  logic [31:0]        req_time_us,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_roll_q14,
   output logic signed [15:0] rsp_pitch_q14,
   output logic signed [15:0] rsp_yaw_q14,
   output logic [14:0]        rsp_throttle_q14,
   output logic               rsp_armed,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);

   rcpn_pkg::cfg_type    cfg_ff;
   rcpn_pkg::edge_type   edge_ev;
   rcpn_pkg::result_type res;
   rcpn_pkg::result_type rsp_res_ff;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [rcpn_pkg::SEL_W-1:0] rd_sel;
   logic [15:0]                rd_width;
   logic                       req_take;
   logic                       seq_idle;
   logic                       res_valid;
   logic                       res_take;

   assign csr_ready = 1'b1;
   assign req_ready = seq_idle;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= rcpn_pkg::CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rcpn_pkg::CSR_PULSE_MIN: cfg_ff.pulse_min <= csr_data;
            rcpn_pkg::CSR_PULSE_MID: cfg_ff.pulse_mid <= csr_data;
            rcpn_pkg::CSR_PULSE_MAX: cfg_ff.pulse_max <= csr_data;
            rcpn_pkg::CSR_DEADBAND:  cfg_ff.deadband  <= csr_data[13:0];
            rcpn_pkg::CSR_ROLL_CH:   cfg_ff.roll_ch   <= csr_data[2:0];
            rcpn_pkg::CSR_PITCH_CH:  cfg_ff.pitch_ch  <= csr_data[2:0];
            rcpn_pkg::CSR_YAW_CH:    cfg_ff.yaw_ch    <= csr_data[2:0];
            rcpn_pkg::CSR_THR_CH:    cfg_ff.thr_ch    <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   assign edge_ev = '{
      valid:   req_take && (req_command == rcpn_pkg::CMD_EDGE),
      channel: req_channel,
      level:   req_level,
      stamp:   req_time_us
   };

   rcpn_pulse_store #(
      .CHANNELS(CHANNELS)
   ) u_store (
      .clock(clock),
      .reset(reset),
      .edge_ev(edge_ev),
      .rd_sel(rd_sel),
      .rd_width(rd_width)
   );

   rcpn_frame_seq #(
      .ARM_CHANNEL(ARM_CHANNEL),
      .FRAC_BITS(FRAC_BITS)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .start(req_take && (req_command == rcpn_pkg::CMD_FRAME)),
      .cfg(cfg_ff),
      .rd_sel(rd_sel),
      .rd_width(rd_width),
      .idle(seq_idle),
      .res_valid(res_valid),
      .res_take(res_take),
      .res(res)
   );

   // The output register loads when it is empty or being emptied this cycle.
   assign res_take = res_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_take) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_roll_q14     = rsp_res_ff.roll;
   assign rsp_pitch_q14    = rsp_res_ff.pitch;
   assign rsp_yaw_q14      = rsp_res_ff.yaw;
   assign rsp_throttle_q14 = rsp_res_ff.throttle;
   assign rsp_armed        = rsp_res_ff.armed;

endmodule

`default_nettype wire

// File: design/rcpn_checker.sv
`default_nettype none

`include "rc_pulse_capture_normalizer_assert.svh"

module rcpn_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_command,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_roll_q14,
   input logic signed [15:0] rsp_pitch_q14,
   input logic signed [15:0] rsp_yaw_q14,
   input logic [14:0]        rsp_throttle_q14,
   input logic               rsp_armed
);

   // A stalled result stays and keeps its payload.
   `RCPN_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_roll_q14) && $stable(rsp_pitch_q14) && $stable(rsp_yaw_q14) && $stable(rsp_throttle_q14) && $stable(rsp_armed), "stalled result changed")

   // An edge beat never produces a result.
   `RCPN_ASSERT_NXT(a_edge_silent, clock, reset, req_valid && req_ready && req_command == rcpn_pkg::CMD_EDGE && !rsp_valid, !rsp_valid, "edge beat produced a result")

   // An accepted frame read closes the input.
   `RCPN_ASSERT_NXT(a_frame_busy, clock, reset, req_valid && req_ready && req_command == rcpn_pkg::CMD_FRAME, !req_ready, "input open during frame")

   // Reset leaves no result pending and the input open.
   `RCPN_ASSERT_ALW(a_reset_clean, clock, reset, !rsp_valid && req_ready, "unclean state after reset")

endmodule

bind rc_pulse_capture_normalizer rcpn_checker u_checker (.*);

`default_nettype wire

// File: bench/tb_rc_pulse_capture_normalizer.sv
module tb_rc_pulse_capture_normalizer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_CH = 6;
   localparam int ARM_CH = 4;
   localparam int FRAC_Q = 14;
   localparam longint UNIT_Q = longint'(1) << FRAC_Q;
   localparam int CYCLE_LIMIT = 1_200_000;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_command;
   logic [2:0]         req_channel;
   logic               req_level;
   logic [31:0]        req_time_us;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_roll_q14;
   logic signed [15:0] rsp_pitch_q14;
   logic signed [15:0] rsp_yaw_q14;
   logic [14:0]        rsp_throttle_q14;
   logic               rsp_armed;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [15:0]        csr_data;

   // Shadow of the block's state, updated as each beat is accepted.
   rcpn_pkg::cfg_type    csr_shadow;
   logic [31:0]          start_mem [NUM_CH];
   logic [15:0]          width_mem [NUM_CH];
   rcpn_pkg::result_type frame_expect_q [$];

   int          send_idle_pct;
   int          recv_idle_pct;
   int          error_count = 0;
   int          beats_sent = 0;
   int          frames_sent = 0;
   int          frames_checked = 0;
   int          csr_writes = 0;
   int          configs_loaded = 0;
   int          cycle_count = 0;
   logic [31:0] stamp_now;

   rc_pulse_capture_normalizer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_channel      (req_channel),
      .req_level        (req_level),
      .req_time_us      (req_time_us),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_roll_q14     (rsp_roll_q14),
      .rsp_pitch_q14    (rsp_pitch_q14),
      .rsp_yaw_q14      (rsp_yaw_q14),
      .rsp_throttle_q14 (rsp_throttle_q14),
      .rsp_armed        (rsp_armed),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint clamp_width(input int unsigned sel);
      longint p;
      longint lo;
      longint hi;
      p = 0;
      lo = longint'(csr_shadow.pulse_min);
      hi = longint'(csr_shadow.pulse_max);
      if (sel < NUM_CH) begin
         p = longint'(width_mem[sel]);
      end
      if (p < lo) return lo;
      if (p > hi) return hi;
      return p;
   endfunction

   function automatic longint scaled_div(input longint num, input longint den);
      if (den == 0) return 0;
      return (num * UNIT_Q) / den;
   endfunction

   function automatic longint stick_q(input logic [2:0] sel);
      longint x;
      longint mid;
      longint db;
      mid = longint'(csr_shadow.pulse_mid);
      x = scaled_div(clamp_width(32'(sel)) - mid, longint'(csr_shadow.pulse_max) - mid);
      db = longint'(csr_shadow.deadband);
      if (x > UNIT_Q) x = UNIT_Q;
      if (x < -UNIT_Q) x = -UNIT_Q;
      if (x <= db && x >= -db) return 0;
      if (x > 0) return scaled_div(x - db, UNIT_Q - db);
      return scaled_div(x + db, UNIT_Q - db);
   endfunction

   function automatic rcpn_pkg::result_type predict_frame();
      rcpn_pkg::result_type r;
      longint               thr;
      longint               lo;
      lo = longint'(csr_shadow.pulse_min);
      thr = scaled_div(clamp_width(32'(csr_shadow.thr_ch)) - lo,
                       longint'(csr_shadow.pulse_max) - lo);
      if (thr < 0) thr = 0;
      if (thr > UNIT_Q) thr = UNIT_Q;
      r.roll     = 16'(stick_q(csr_shadow.roll_ch));
      r.pitch    = 16'(stick_q(csr_shadow.pitch_ch));
      r.yaw      = 16'(stick_q(csr_shadow.yaw_ch));
      r.throttle = thr[14:0];
      r.armed    = (thr * 20 < UNIT_Q) &&
                   (clamp_width(ARM_CH) > longint'(csr_shadow.pulse_mid));
      return r;
   endfunction

   function automatic void apply_edge(input logic [2:0] ch, input logic lvl,
                                      input logic [31:0] stamp);
      logic [31:0] span;
      if (ch < NUM_CH) begin
         if (lvl) begin
            start_mem[ch] = stamp;
         end else begin
            span = stamp - start_mem[ch];
            width_mem[ch] = (span > 32'hFFFF) ? 16'hFFFF : span[15:0];
         end
      end
   endfunction

   function automatic void apply_csr(input logic [2:0] idx, input logic [15:0] data);
      case (idx)
         rcpn_pkg::CSR_PULSE_MIN: csr_shadow.pulse_min = data;
         rcpn_pkg::CSR_PULSE_MID: csr_shadow.pulse_mid = data;
         rcpn_pkg::CSR_PULSE_MAX: csr_shadow.pulse_max = data;
         rcpn_pkg::CSR_DEADBAND:  csr_shadow.deadband  = data[13:0];
         rcpn_pkg::CSR_ROLL_CH:   csr_shadow.roll_ch   = data[2:0];
         rcpn_pkg::CSR_PITCH_CH:  csr_shadow.pitch_ch  = data[2:0];
         rcpn_pkg::CSR_YAW_CH:    csr_shadow.yaw_ch    = data[2:0];
         rcpn_pkg::CSR_THR_CH:    csr_shadow.thr_ch    = data[2:0];
         default: ;
      endcase
   endfunction

   function automatic void reset_shadow();
      csr_shadow = rcpn_pkg::CFG_RESET;
      for (int i = 0; i < NUM_CH; i++) begin
         start_mem[i] = '0;
         width_mem[i] = csr_shadow.pulse_mid;
      end
      if (csr_shadow.thr_ch < NUM_CH) width_mem[csr_shadow.thr_ch] = csr_shadow.pulse_min;
   endfunction

   function automatic rcpn_pkg::cfg_type make_cfg(input logic [15:0] lo,
                                                  input logic [15:0] mid,
                                                  input logic [15:0] hi,
                                                  input logic [13:0] db,
                                                  input logic [2:0] r, input logic [2:0] p,
                                                  input logic [2:0] y, input logic [2:0] t);
      rcpn_pkg::cfg_type c;
      c.pulse_min = lo;
      c.pulse_mid = mid;
      c.pulse_max = hi;
      c.deadband  = db;
      c.roll_ch   = r;
      c.pitch_ch  = p;
      c.yaw_ch    = y;
      c.thr_ch    = t;
      return c;
   endfunction

   // ------------------------------------------------------------ result check

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      rcpn_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_expect_q.size() == 0) begin
            $display("%0t ns: result beat with no frame read pending, expected none, actual %0d",
                     $time, rsp_roll_q14);
            error_count++;
         end else begin
            want = frame_expect_q.pop_front();
            check_field("roll", int'($signed(want.roll)), int'(rsp_roll_q14));
            check_field("pitch", int'($signed(want.pitch)), int'(rsp_pitch_q14));
            check_field("yaw", int'($signed(want.yaw)), int'(rsp_yaw_q14));
            check_field("throttle", int'(want.throttle), int'(rsp_throttle_q14));
            check_field("armed", int'(want.armed), int'(rsp_armed));
            frames_checked++;
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // ---------------------------------------------------------------- drivers

   task automatic send_beat(input logic cmd, input logic [2:0] ch, input logic lvl,
                            input logic [31:0] stamp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_channel <= ch;
      req_level   <= lvl;
      req_time_us <= stamp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
      if (cmd == rcpn_pkg::CMD_FRAME) begin
         frame_expect_q.push_back(predict_frame());
         frames_sent++;
      end else begin
         apply_edge(ch, lvl, stamp);
      end
   endtask

   task automatic send_pulse(input logic [2:0] ch, input logic [31:0] rise_at,
                             input logic [31:0] fall_at);
      send_beat(rcpn_pkg::CMD_EDGE, ch, 1'b1, rise_at);
      send_beat(rcpn_pkg::CMD_EDGE, ch, 1'b0, fall_at);
   endtask

   // Edge beats take effect as they are accepted, so an empty queue plus a short pause
   // means the block is idle.
   task automatic settle_idle();
      req_valid <= 1'b0;
      while (frame_expect_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic load_config(input rcpn_pkg::cfg_type c);
      logic [2:0]  idx [8];
      logic [15:0] val [8];
      logic [31:0] junk;
      junk = $urandom;
      idx[0] = rcpn_pkg::CSR_PULSE_MIN; val[0] = c.pulse_min;
      idx[1] = rcpn_pkg::CSR_PULSE_MID; val[1] = c.pulse_mid;
      idx[2] = rcpn_pkg::CSR_PULSE_MAX; val[2] = c.pulse_max;
      idx[3] = rcpn_pkg::CSR_DEADBAND;  val[3] = {junk[15:14], c.deadband};
      idx[4] = rcpn_pkg::CSR_ROLL_CH;   val[4] = {junk[28:16], c.roll_ch};
      idx[5] = rcpn_pkg::CSR_PITCH_CH;  val[5] = {junk[15:3], c.pitch_ch};
      idx[6] = rcpn_pkg::CSR_YAW_CH;    val[6] = {junk[31:19], c.yaw_ch};
      idx[7] = rcpn_pkg::CSR_THR_CH;    val[7] = {junk[20:8], c.thr_ch};
      for (int k = 0; k < 8; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data  <= val[k];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         apply_csr(idx[k], val[k]);
         csr_writes++;
      end
      csr_valid <= 1'b0;
      configs_loaded++;
   endtask

   // Mostly complete rise/fall pairs, with frame reads, stray edges and noise.
   task automatic pulse_burst(input int n_items);
      int          done;
      int          pick;
      logic [2:0]  ch;
      logic [31:0] width;
      done = 0;
      while (done < n_items) begin
         pick = $urandom_range(99);
         if (pick < 6) begin
            send_beat(1'($urandom_range(1)), 3'($urandom_range(7)),
                      1'($urandom_range(1)), $urandom);
            done++;
         end else if (pick < 11) begin
            stamp_now += $urandom_range(3000, 1);
            send_beat(rcpn_pkg::CMD_EDGE, 3'($urandom_range(5)), 1'($urandom_range(1)),
                      stamp_now);
            done++;
         end else if (pick < 26) begin
            send_beat(rcpn_pkg::CMD_FRAME, 3'($urandom_range(7)), 1'($urandom_range(1)),
                      $urandom);
            done++;
         end else begin
            ch = 3'($urandom_range(5));
            pick = $urandom_range(99);
            if (pick < 75) width = $urandom_range(2300, 700);
            else if (pick < 92) width = $urandom_range(65535);
            else width = $urandom;
            stamp_now += $urandom_range(5000, 1);
            send_beat(rcpn_pkg::CMD_EDGE, ch, 1'b1, stamp_now);
            stamp_now += width;
            send_beat(rcpn_pkg::CMD_EDGE, ch, 1'b0, stamp_now);
            done += 2;
         end
      end
   endtask

   // ------------------------------------------------------------------ tests

   task automatic test_reset_state();
      send_beat(rcpn_pkg::CMD_FRAME, 3'd0, 1'b0, 32'd0);
   endtask

   task automatic test_directed_edges();
      send_pulse(3'd0, 32'hFFFF_FF00, 32'h0000_0600);   // timestamp wraps mid-pulse
      send_pulse(3'd1, 32'h0000_0000, 32'hFFFF_FFFF);   // saturates to 16 bits
      send_beat(rcpn_pkg::CMD_EDGE, 3'd3, 1'b0, 32'd500);         // fall with no rise seen
      send_pulse(3'd4, 32'd1000, 32'd2900);             // arm switch high
      send_pulse(3'd2, 32'd5000, 32'd6020);             // throttle just off the bottom
      // Channels past the end are ignored.
      send_beat(rcpn_pkg::CMD_EDGE, 3'd6, 1'b1, 32'h8000_0001);
      send_beat(rcpn_pkg::CMD_EDGE, 3'd7, 1'b0, 32'h7FFF_FFFE);
      send_beat(rcpn_pkg::CMD_FRAME, 3'd7, 1'b1, 32'hFFFF_FFFF);
      send_pulse(3'd0, 32'd100, 32'd1625);              // exactly on the deadband edge
      send_pulse(3'd1, 32'd100, 32'd1575);
      send_pulse(3'd3, 32'd100, 32'd1626);              // just outside the deadband
      send_pulse(3'd2, 32'd100, 32'd2100);              // full throttle disarms
      send_pulse(3'd5, 32'hAAAA_5555, 32'hAAAA_5B2D);
      send_beat(rcpn_pkg::CMD_FRAME, 3'd0, 1'b0, 32'd0);
   endtask

   task automatic test_config_corners();
      rcpn_pkg::cfg_type corners [6];
      corners[0] = make_cfg(16'd0, 16'd0, 16'hFFFF, 14'd0, 3'd0, 3'd1, 3'd3, 3'd2);
      corners[1] = make_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 14'h3FFF, 3'd5, 3'd4, 3'd0, 3'd1);
      corners[2] = make_cfg(16'd2000, 16'd1500, 16'd1000, 14'd100, 3'd5, 3'd4, 3'd2, 3'd3);
      corners[3] = make_cfg(16'd1000, 16'd2000, 16'd2000, 14'd819, 3'd2, 3'd0, 3'd1, 3'd4);
      corners[4] = make_cfg(16'd1000, 16'd1500, 16'd2000, 14'd819, 3'd6, 3'd7, 3'd6, 3'd7);
      corners[5] = make_cfg(16'd1000, 16'd1500, 16'd2000, 14'd819, 3'd0, 3'd1, 3'd3, 3'd2);
      foreach (corners[i]) begin
         settle_idle();
         load_config(corners[i]);
         pulse_burst(30);
      end
   endtask

   task automatic test_random_traffic();
      rcpn_pkg::cfg_type c;
      for (int phase = 0; phase < 3; phase++) begin
         settle_idle();
         send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 63 : 0;
         recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 31 : 0;
         c = make_cfg(16'($urandom_range(1100, 900)), 16'($urandom_range(1600, 1400)),
                      16'($urandom_range(2100, 1900)), 14'($urandom_range(4000)),
                      3'($urandom_range(5)), 3'($urandom_range(5)), 3'($urandom_range(5)),
                      3'($urandom_range(5)));
         if ($urandom_range(3) == 0) c.yaw_ch = 3'($urandom_range(7, 6));
         load_config(c);
         pulse_burst(430);
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_command = rcpn_pkg::CMD_EDGE;
      req_channel = 3'd0;
      req_level   = 1'b0;
      req_time_us = 32'd0;
      rsp_ready   = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = rcpn_pkg::CSR_PULSE_MIN;
      csr_data    = 16'd0;
      send_idle_pct = 31;
      recv_idle_pct = 63;
      stamp_now   = $urandom;
      reset_shadow();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_directed_edges();
      test_config_corners();
      test_random_traffic();

      settle_idle();
      repeat (200) @(posedge clock);

      $display("Sent %0d request beats, %0d of them frame reads; %0d results checked.",
               beats_sent, frames_sent, frames_checked);
      $display("Loaded %0d register sets (%0d writes), limits at their extremes included.",
               configs_loaded, csr_writes);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
